/* hw/rtl/lgu_pkg.sv */
package lgu_pkg;

  typedef enum logic [2:0] {
    MODE_MSE   = 3'd0,
    MODE_MAE   = 3'd1,
    MODE_BCE   = 3'd2,
    MODE_CCE   = 3'd3,
    MODE_HINGE = 3'd4,
    MODE_HUBER = 3'd5
  } loss_mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SAT      = 2'd1,
    STAT_ZERO_DIV = 2'd2
  } status_t;

  localparam logic [1:0] REG_LOSS_MODE    = 2'd0;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] REG_HUBER_THRESH = 2'd2;

endpackage

/* hw/rtl/loss_gradient_unit_core.sv */
// Loss gradient unit: one prediction/target word in, one gradient/status word out.
// Input channel in_valid/in_ready carries prediction and target (signed fixed
// point); output channel out_valid/out_ready carries gradient and status.
// The loss is chosen through the register port: loss_mode at 0x0, output_count
// at 0x4, huber_thresh at 0x8. Write registers only while no word is in flight.
// Throughput: one word per cycle while the receiver does not stall. The word
// passes a row of registers, with the divider cells producing one quotient bit
// each: an input stage with the multipliers, one cell per quotient bit, and
// the output register with saturation.
// Every word takes the same path, so results leave in input order.
// When the receiver stalls, the whole row holds and in_ready falls only while
// a finished word waits in the output register.
// Reset clears all valid flags and loads loss_mode 0 (mse), output_count 1 and
// huber_thresh 1.0; no words are in flight afterwards.
module loss_gradient_unit_core #(
  parameter int FRAC_BITS  = 12,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] prediction,
  input  logic signed [DATA_WIDTH-1:0] target,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] gradient,
  output lgu_pkg::status_t             status
);
  import lgu_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int AW     = DW + F + 2;
  localparam int NUM_W  = DW + F + 1;
  localparam int OMP_W  = ((DW > F + 1) ? DW : F + 1) + 1;
  localparam int PW     = DW + OMP_W;
  localparam int HW     = 2 * DW;
  localparam int HW2    = HW + 2;
  localparam int DEN_W  = ((PW - F) > 16) ? (PW - F) : 16;
  localparam int SIDE_W = AW + 3;

  localparam logic signed [AW-1:0]    ONE_A = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [OMP_W-1:0] ONE_O = {{(OMP_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [HW2-1:0]   ONE_H = {{(HW2-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [AW-1:0]    MAX_A = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0]    MIN_A = ~MAX_A;
  localparam logic [DW-2:0]           DELTA_RST = (DW-1)'(64'd1 << F);

  // configuration registers
  logic [2:0]    loss_mode;
  logic [15:0]   output_count;
  logic [DW-2:0] huber_thresh;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_mode    <= MODE_MSE;
      output_count <= 16'd1;
      huber_thresh <= DELTA_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LOSS_MODE:    loss_mode    <= pwdata[2:0];
        REG_OUTPUT_COUNT: output_count <= pwdata[15:0];
        REG_HUBER_THRESH: huber_thresh <= pwdata[DW-2:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOSS_MODE:    prdata = {29'd0, loss_mode};
      REG_OUTPUT_COUNT: prdata = {16'd0, output_count};
      REG_HUBER_THRESH: prdata = {{(33-DW){1'b0}}, huber_thresh};
      default:          prdata = 32'd0;
    endcase
  end

  // whole row advances unless a finished word is stuck in the output register
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input stage: capture the word and form both products
  logic                 s0_valid;
  logic signed [DW-1:0] s0_p;
  logic signed [DW-1:0] s0_a;
  logic signed [PW-1:0] s0_pb;
  logic signed [HW-1:0] s0_ph;
  logic [2:0]           s0_mode;
  logic [15:0]          s0_cnt;
  logic [DW-2:0]        s0_delta;
  logic signed [OMP_W-1:0] one_minus_p;

  assign one_minus_p = ONE_O - OMP_W'(prediction);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_p     <= prediction;
      s0_a     <= target;
      s0_pb    <= PW'(prediction) * PW'(one_minus_p);
      s0_ph    <= HW'(prediction) * HW'(target);
      s0_mode  <= loss_mode;
      s0_cnt   <= output_count;
      s0_delta <= huber_thresh;
    end
  end

  // set up the division, or the direct result for modes that need none
  logic signed [AW-1:0]  p_x, a_x, diff, e, e_mag, diff_mag;
  logic [PW-1:0]         pb_mag;
  logic [PW-F-1:0]       d_mag;
  logic [HW-1:0]         ph_mag;
  logic [HW-F-1:0]       h_q;
  logic signed [HW2-1:0] h_qs;
  logic signed [AW-1:0]  delta_x;
  logic                  is_div, neg, zflag;
  logic signed [AW-1:0]  alt;
  logic [NUM_W-1:0]      num;
  logic [DEN_W-1:0]      den;

  always_comb begin
    p_x      = AW'(s0_p);
    a_x      = AW'(s0_a);
    diff     = p_x - a_x;
    diff_mag = diff[AW-1] ? -diff : diff;
    e        = a_x - p_x;
    e_mag    = e[AW-1] ? -e : e;
    delta_x  = AW'({1'b0, s0_delta});
    pb_mag   = s0_pb[PW-1] ? PW'(-s0_pb) : PW'(s0_pb);
    d_mag    = pb_mag[PW-1:F];
    ph_mag   = s0_ph[HW-1] ? HW'(-s0_ph) : HW'(s0_ph);
    h_q      = ph_mag[HW-1:F];
    h_qs     = s0_ph[HW-1] ? -HW2'(h_q) : HW2'(h_q);
    is_div   = 1'b0;
    neg      = 1'b0;
    zflag    = 1'b0;
    alt      = '0;
    num      = '0;
    den      = DEN_W'(1);
    case (s0_mode)
      MODE_MSE: begin
        is_div = 1'b1;
        neg    = diff[AW-1];
        num    = {diff_mag[NUM_W-2:0], 1'b0};
        den    = (s0_cnt == 16'd0) ? DEN_W'(1) : DEN_W'(s0_cnt);
      end
      MODE_MAE: begin
        if (s0_p > s0_a) alt = ONE_A;
        else if (s0_p == s0_a) alt = AW'(1);
        else alt = -ONE_A;
      end
      MODE_BCE: begin
        if (d_mag == '0) begin
          zflag = 1'b1;
        end else begin
          is_div = 1'b1;
          neg    = diff[AW-1] ^ s0_pb[PW-1];
          num    = {diff_mag[DW:0], {F{1'b0}}};
          den    = DEN_W'(d_mag);
        end
      end
      MODE_CCE:   alt = (a_x == ONE_A) ? p_x - ONE_A : p_x;
      MODE_HINGE: alt = (ONE_H > h_qs) ? -a_x : '0;
      MODE_HUBER: begin
        if (e_mag <= delta_x) alt = -e;
        else if (!e[AW-1]) alt = -delta_x;
        else alt = delta_x;
      end
      default: ;
    endcase
  end

  // divider row: one cell per quotient bit
  logic              c_vld  [NUM_W+1];
  logic [DEN_W-1:0]  c_rem  [NUM_W+1];
  logic [NUM_W-1:0]  c_nq   [NUM_W+1];
  logic [DEN_W-1:0]  c_den  [NUM_W+1];
  logic [SIDE_W-1:0] c_side [NUM_W+1];

  assign c_vld[0]  = s0_valid;
  assign c_rem[0]  = '0;
  assign c_nq[0]   = num;
  assign c_den[0]  = den;
  assign c_side[0] = {is_div, neg, zflag, alt};

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    lgu_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (c_vld[i]),
      .in_rem  (c_rem[i]),
      .in_nq   (c_nq[i]),
      .in_den  (c_den[i]),
      .in_side (c_side[i]),
      .out_vld (c_vld[i+1]),
      .out_rem (c_rem[i+1]),
      .out_nq  (c_nq[i+1]),
      .out_den (c_den[i+1]),
      .out_side(c_side[i+1])
    );
  end

  // output stage: sign the quotient, pick the result, saturate
  logic                 f_div, f_neg, f_zero;
  logic signed [AW-1:0] f_alt, f_q, f_res;

  always_comb begin
    {f_div, f_neg, f_zero, f_alt} = c_side[NUM_W];
    f_q   = f_neg ? -AW'(c_nq[NUM_W]) : AW'(c_nq[NUM_W]);
    f_res = f_div ? f_q : f_alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_res > MAX_A) begin
        gradient <= MAX_A[DW-1:0];
        status   <= STAT_SAT;
      end else if (f_res < MIN_A) begin
        gradient <= MIN_A[DW-1:0];
        status   <= STAT_SAT;
      end else begin
        gradient <= f_res[DW-1:0];
        status   <= f_zero ? STAT_ZERO_DIV : STAT_OK;
      end
    end
  end

endmodule

/* hw/rtl/lgu_div_cell.sv */
module lgu_div_cell #(
  parameter int NUM_W  = 29,
  parameter int DEN_W  = 21,
  parameter int SIDE_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [NUM_W-1:0]  in_nq,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [DEN_W-1:0]  out_rem,
  output logic [NUM_W-1:0]  out_nq,
  output logic [DEN_W-1:0]  out_den,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] sub;
  logic           ge;

  // one restoring step: bring down the next dividend bit, shift in a quotient bit
  always_comb begin
    trial = {in_rem, in_nq[NUM_W-1]};
    sub   = trial - {1'b0, in_den};
    ge    = (trial >= {1'b0, in_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
      out_nq   <= {in_nq[NUM_W-2:0], ge};
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule

/* dv/loss_gradient_unit_core_test.sv */
module loss_gradient_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lgu_pkg::*;

  localparam int ONE = 4096;
  localparam int LATENCY = 31;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] prediction = '0;
  logic signed [15:0] target = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] gradient;
  status_t status;

  typedef struct packed {
    logic signed [15:0] gradient;
    status_t status;
  } grad_word_t;

  grad_word_t grad_queue[$];
  logic [2:0] cur_mode;
  logic [15:0] cur_count;
  logic [14:0] cur_delta;
  int errors = 0;
  int cycles = 0;
  int stall_pct = 30;

  loss_gradient_unit_core u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls in runs; stall_pct 0 gives stretches with no stall.
  always @(posedge clk) begin
    if ($urandom_range(99) < 8)
      stall_pct <= $urandom_range(3) == 0 ? 0 : $urandom_range(80);
    out_ready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (grad_queue.size() == 0) begin
        $error("unexpected gradient word %0d", gradient);
        errors++;
      end else begin
        grad_word_t w;
        w = grad_queue.pop_front();
        if (gradient !== w.gradient) begin
          $error("gradient expected %0d actual %0d", w.gradient, gradient);
          errors++;
        end
        if (status !== w.status) begin
          $error("status expected %0d actual %0d", w.status, status);
          errors++;
        end
      end
    end
  end

  function automatic grad_word_t loss_gradient(logic signed [15:0] pr,
                                               logic signed [15:0] ta);
    longint p, a, r, d, cnt, e, mag, v;
    grad_word_t w;
    p = pr;
    a = ta;
    r = 0;
    w.status = STAT_OK;
    case (cur_mode)
      MODE_MSE: begin
        cnt = (cur_count == 0) ? 1 : cur_count;
        r = (2 * (p - a)) / cnt;
      end
      MODE_MAE: r = (p > a) ? ONE : ((p == a) ? 1 : -ONE);
      MODE_BCE: begin
        d = (p * (ONE - p)) / ONE;
        if (d == 0) w.status = STAT_ZERO_DIV;
        else r = ((p - a) * ONE) / d;
      end
      MODE_CCE: r = (a == ONE) ? p - ONE : p;
      MODE_HINGE: begin
        v = ONE - (p * a) / ONE;
        r = (v > 0) ? -a : 0;
      end
      MODE_HUBER: begin
        e = a - p;
        mag = (e < 0) ? -e : e;
        if (mag <= cur_delta) r = -e;
        else r = (e > 0) ? -longint'(cur_delta) : longint'(cur_delta);
      end
      default: r = 0;
    endcase
    if (r > 32767) begin
      r = 32767;
      w.status = STAT_SAT;
    end else if (r < -32768) begin
      r = -32768;
      w.status = STAT_SAT;
    end
    w.gradient = r[15:0];
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOSS_MODE: cur_mode = val[2:0];
      REG_OUTPUT_COUNT: cur_count = val[15:0];
      default: cur_delta = val[14:0];
    endcase
  endtask

  task automatic send_pair(logic signed [15:0] p, logic signed [15:0] a);
    in_valid <= 1'b1;
    prediction <= p;
    target <= a;
    grad_queue.push_back(loss_gradient(p, a));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(6, 1)) @(posedge clk);
  endtask

  // Drain fully, then hold for the pipeline depth before touching registers.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grad_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] mode, logic [15:0] count, logic [14:0] delta);
    wait_drain();
    write_reg(REG_LOSS_MODE, {29'd0, mode});
    write_reg(REG_OUTPUT_COUNT, {16'd0, count});
    write_reg(REG_HUBER_THRESH, {17'd0, delta});
  endtask

  task automatic test_directed();
    logic signed [15:0] edge_vals[8];
    edge_vals = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd4096, -16'sd4096,
                  16'sd1, -16'sd1, 16'sd2048};
    for (int m = 0; m < 8; m++) begin
      configure(m[2:0], (m == 0) ? 16'd0 : 16'd1, 15'd4096);
      send_pair(16'sd4096, 16'sd4096);
      send_pair(-16'sd32768, 16'sd32767);
      send_pair(16'sd32767, -16'sd32768);
      send_pair(16'sd0, 16'sd100);
      send_pair(16'sd2000, 16'sd4096);
      send_pair(16'sd4096, -16'sd32768);
      send_pair(edge_vals[m], edge_vals[7 - m]);
    end
  endtask

  task automatic test_random_phase(int n, logic [2:0] mode, logic [15:0] count,
                                   logic [14:0] delta);
    int burst;
    logic signed [15:0] p, a;
    configure(mode, count, delta);
    burst = $urandom_range(20, 1);
    for (int i = 0; i < n; i++) begin
      p = 16'($urandom);
      a = 16'($urandom);
      case ($urandom_range(5))
        0: a = (mode == MODE_CCE) ? 16'sd4096 : p;
        1: p = 16'($urandom_range(8192) - 2048);
        2: a = p + $signed(16'($urandom_range(64) - 32));
        default: ;
      endcase
      send_pair(p, a);
      if (--burst == 0) begin
        idle_sender();
        burst = $urandom_range(20, 1);
      end
    end
  endtask

  task automatic test_random();
    test_random_phase(60, MODE_MSE, 16'd1, 15'd0);
    test_random_phase(50, MODE_MSE, 16'd65535, 15'd0);
    test_random_phase(50, MODE_MSE, 16'($urandom_range(65535)), 15'd0);
    test_random_phase(70, MODE_MAE, 16'd3, 15'd100);
    test_random_phase(90, MODE_BCE, 16'd1, 15'd1);
    test_random_phase(70, MODE_CCE, 16'd1, 15'd1);
    test_random_phase(80, MODE_HINGE, 16'd1, 15'd1);
    test_random_phase(50, MODE_HUBER, 16'd1, 15'd0);
    test_random_phase(50, MODE_HUBER, 16'd1, 15'd32767);
    test_random_phase(60, MODE_HUBER, 16'd1, 15'($urandom_range(32767)));
    test_random_phase(40, 3'd7, 16'd0, 15'd4096);
    test_random_phase(30, 3'($urandom_range(7)), 16'($urandom), 15'($urandom));
  endtask

  initial begin
    cur_mode = MODE_MSE;
    cur_count = 16'd1;
    cur_delta = 15'd4096;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    wait_drain();
    if (errors == 0 && grad_queue.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
